>>> hdl/rgcs_pkg.sv
// Package for the render-gated capture suppressor.
// Holds field widths, register codes, reset values and queue command codes.
// No dependencies; the files that use it refer to it by scoped name.
package rgcs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MEAN_W     = 16;
   localparam int HOLD_W     = 32;
   localparam int RATE_W     = 18;
   localparam int MS_W       = 16;
   localparam int THR_W      = 16;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_IDX_W  = 2;

   // milliseconds per second
   localparam int MS_PER_S   = 1000;

   // hold length = (rate * ms >> 3) / 125 by reciprocal multiplication;
   // exact for a shifted product below 2^31
   localparam int                 RECIP_PRE_SHIFT = 3;
   localparam int                 RECIP_W         = 32;
   localparam int                 RECIP_SHIFT     = 38;
   localparam logic [RECIP_W-1:0] RECIP_125       = 32'd2199023256;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = RATE_W'(8000);
   localparam logic [MS_W-1:0]   HOLD_MS_RST     = MS_W'(200);
   localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(1000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SAMPLE_RATE      = 2'd0,
      REG_HOLD_MS          = 2'd1,
      REG_ACTIVE_THRESHOLD = 2'd2
   } csr_reg_type;

   typedef enum logic {
      FUNC_RENDER  = 1'b0,
      FUNC_CAPTURE = 1'b1
   } func_type;

   // command kinds carried through the queue from front to back
   typedef enum logic {
      CMD_FRAME   = 1'b0,
      CMD_CAPTURE = 1'b1
   } cmd_type;

endpackage

>>> hdl/rgcs_channels.sv
// Valid/ready channel interfaces for the suppressor's request and response sides.
// Depends on rgcs_pkg for the field widths.
interface rgcs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [rgcs_pkg::SAMPLE_W-1:0] sample;
   logic                                frame_end;

   modport source (output valid, func, sample, frame_end, input ready);
   modport sink   (input valid, func, sample, frame_end, output ready);
endinterface

interface rgcs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_frame_result;
   logic signed [rgcs_pkg::SAMPLE_W-1:0] out_sample;
   logic        [rgcs_pkg::MEAN_W-1:0]   mean_level;
   logic                                suppressing;
   logic                                changed;
   logic                                frame_overflow;

   modport source (output valid, is_frame_result, out_sample, mean_level, suppressing,
                   changed, frame_overflow, input ready);
   modport sink   (input valid, is_frame_result, out_sample, mean_level, suppressing,
                   changed, frame_overflow, output ready);
endinterface

>>> hdl/rgcs_fifo.sv
// Small register queue between the front and back parts.
// Generic in width and depth; no package dependencies.
module rgcs_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push && full |-> pop)
      else $error("queue written while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
`endif

endmodule

>>> hdl/rgcs_front.sv
// Front part: takes request transactions, accumulates render frame statistics
// and queues one command per capture sample or frame end. Uses rgcs_pkg, rgcs_req_if.
module rgcs_front #(
   parameter int MAX_FRAME = 4096
) (
   input  logic              clock,
   input  logic              reset,
   rgcs_req_if.sink          req_ch,
   input  logic              q_full,
   output logic              q_push,
   output logic [2 + rgcs_pkg::SAMPLE_W + $clog2(MAX_FRAME + 1)
                 + rgcs_pkg::SAMPLE_W + $clog2(MAX_FRAME + 1) - 1:0] q_data
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int SUM_W = rgcs_pkg::SAMPLE_W + CNT_W;

   logic [SUM_W-1:0]              sum_ff, sum_in, sum_upd;
   logic [CNT_W-1:0]              count_ff, count_in, count_upd;
   logic                          ovf_ff, ovf_in, ovf_upd;
   logic [rgcs_pkg::SAMPLE_W-1:0] raw;
   logic [rgcs_pkg::SAMPLE_W-1:0] mag;
   logic                          accept;
   logic                          is_render;
   logic                          room;
   rgcs_pkg::cmd_type             kind;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_render    = (rgcs_pkg::func_type'(req_ch.func) == rgcs_pkg::FUNC_RENDER);
   assign raw          = req_ch.sample;
   // two's complement magnitude; the most negative sample maps to 0x8000 unsigned
   assign mag          = raw[rgcs_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
   assign room         = (count_ff < CNT_W'(MAX_FRAME));

   assign sum_upd   = room ? sum_ff + SUM_W'(mag) : sum_ff;
   assign count_upd = room ? count_ff + 1'b1 : count_ff;
   assign ovf_upd   = ovf_ff || !room;

   assign kind   = is_render ? rgcs_pkg::CMD_FRAME : rgcs_pkg::CMD_CAPTURE;
   assign q_push = accept && (!is_render || req_ch.frame_end);
   assign q_data = {kind, raw, ovf_upd, count_upd, sum_upd};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept && is_render) begin
         if (req_ch.frame_end) begin
            sum_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_upd;
            count_in = count_upd;
            ovf_in   = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

>>> hdl/rgcs_divider.sv
// Restoring divider, one quotient bit per cycle.
// Generic in dividend and divisor widths; no package dependencies.
module rgcs_divider #(
   parameter int N_W = 34,
   parameter int D_W = 13
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int STEP_W = $clog2(N_W + 1);

   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [N_W-1:0]    quo_ff;
   logic [D_W-1:0]    rem_ff;
   logic [D_W-1:0]    dsr_ff;
   logic [D_W:0]      trial;
   logic [D_W:0]      diff;
   logic              fits;

   assign trial    = {rem_ff, quo_ff[N_W-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(N_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder stays below the divisor, so it fits in D_W bits
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[N_W-2:0], fits};
         rem_ff <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      end
   end

endmodule

>>> hdl/rgcs_back.sv
// Back part: executes queued commands, keeps the hold counter and configuration,
// and drives the response register. Uses rgcs_pkg, rgcs_rsp_if and rgcs_divider.
module rgcs_back #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rgcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rgcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             q_empty,
   input  logic [2 + rgcs_pkg::SAMPLE_W + $clog2(MAX_FRAME + 1)
                 + rgcs_pkg::SAMPLE_W + $clog2(MAX_FRAME + 1) - 1:0] q_data,
   output logic                             q_pop,
   rgcs_rsp_if.source                       rsp_ch
);

   localparam int CNT_W      = $clog2(MAX_FRAME + 1);
   localparam int SUM_W      = rgcs_pkg::SAMPLE_W + CNT_W;
   localparam int ENTRY_W    = 2 + rgcs_pkg::SAMPLE_W + CNT_W + SUM_W;
   localparam int PROD_W     = rgcs_pkg::RATE_W + rgcs_pkg::MS_W;
   localparam int DIV_N_W    = SUM_W;
   localparam int DIV_D_W    = CNT_W;
   localparam int SCALE_IN_W = PROD_W - rgcs_pkg::RECIP_PRE_SHIFT;
   localparam int SCALED_W   = SCALE_IN_W + rgcs_pkg::RECIP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_DECIDE,
      ST_MUL,
      ST_SCALE,
      ST_HOLD,
      ST_OUT
   } state_type;

   state_type                          state_ff;

   logic [rgcs_pkg::RATE_W-1:0]        rate_ff;
   logic [rgcs_pkg::MS_W-1:0]          hold_ms_ff;
   logic [rgcs_pkg::THR_W-1:0]         thr_ff;

   logic [rgcs_pkg::HOLD_W-1:0]        hold_ff;
   logic [rgcs_pkg::MEAN_W-1:0]        last_mean_ff;
   logic [CNT_W-1:0]                   count_ff;
   logic                               ovf_ff;
   logic [PROD_W-1:0]                  prod_ff;
   logic [SCALED_W-1:0]                scaled_ff;

   logic                               pend_frame_ff;
   logic [rgcs_pkg::SAMPLE_W-1:0]      pend_sample_ff;
   logic                               pend_sup_ff;
   logic                               pend_changed_ff;
   logic                               pend_ovf_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_frame_ff;
   logic [rgcs_pkg::SAMPLE_W-1:0]      rsp_sample_ff;
   logic [rgcs_pkg::MEAN_W-1:0]        rsp_mean_ff;
   logic                               rsp_sup_ff;
   logic                               rsp_changed_ff;
   logic                               rsp_ovf_ff;

   logic [SUM_W-1:0]                   q_sum;
   logic [CNT_W-1:0]                   q_count;
   logic                               q_ovf;
   logic [rgcs_pkg::SAMPLE_W-1:0]      q_sample;
   rgcs_pkg::cmd_type                  q_kind;

   logic                               div_start;
   logic [DIV_N_W-1:0]                 div_dividend;
   logic [DIV_D_W-1:0]                 div_divisor;
   logic                               div_done;
   logic [DIV_N_W-1:0]                 div_quotient;

   logic [rgcs_pkg::MEAN_W-1:0]        mean_sat;
   logic [rgcs_pkg::HOLD_W-1:0]        hold_len;
   logic [rgcs_pkg::HOLD_W-1:0]        hold_decay;
   logic                               hold_on;
   logic                               out_free;

   assign q_sum    = q_data[SUM_W-1:0];
   assign q_count  = q_data[SUM_W +: CNT_W];
   assign q_ovf    = q_data[SUM_W + CNT_W];
   assign q_sample = q_data[SUM_W + CNT_W + 1 +: rgcs_pkg::SAMPLE_W];
   assign q_kind   = rgcs_pkg::cmd_type'(q_data[ENTRY_W-1]);

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign hold_on  = (hold_ff != '0);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // the divider serves only the frame mean
   assign div_start    = q_pop && (q_kind == rgcs_pkg::CMD_FRAME);
   assign div_dividend = q_sum;
   assign div_divisor  = q_count;

   assign mean_sat   = (count_ff == '0) ? '0 :
                       (|div_quotient[DIV_N_W-1:rgcs_pkg::MEAN_W]) ? '1 :
                       div_quotient[rgcs_pkg::MEAN_W-1:0];
   // the largest hold length stays below 2^25, so it needs no saturation
   assign hold_len   = rgcs_pkg::HOLD_W'(scaled_ff[SCALED_W-1:rgcs_pkg::RECIP_SHIFT]);
   assign hold_decay = (hold_ff > rgcs_pkg::HOLD_W'(count_ff))
                       ? hold_ff - rgcs_pkg::HOLD_W'(count_ff) : '0;

   rgcs_divider #(
      .N_W (DIV_N_W),
      .D_W (DIV_D_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= rgcs_pkg::SAMPLE_RATE_RST;
         hold_ms_ff   <= rgcs_pkg::HOLD_MS_RST;
         thr_ff       <= rgcs_pkg::THRESHOLD_RST;
         hold_ff      <= '0;
         last_mean_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (rgcs_pkg::csr_reg_type'(csr_index))
               rgcs_pkg::REG_SAMPLE_RATE:      rate_ff    <= csr_wdata[rgcs_pkg::RATE_W-1:0];
               rgcs_pkg::REG_HOLD_MS:          hold_ms_ff <= csr_wdata[rgcs_pkg::MS_W-1:0];
               rgcs_pkg::REG_ACTIVE_THRESHOLD: thr_ff     <= csr_wdata[rgcs_pkg::THR_W-1:0];
               default: ;
            endcase
         end

         // in ST_OUT the response register is reloaded whenever it is free
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  if (q_kind == rgcs_pkg::CMD_CAPTURE) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_MEAN;
                  end
               end
            end
            ST_MEAN: begin
               if (div_done) begin
                  last_mean_ff <= mean_sat;
                  state_ff     <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (last_mean_ff >= thr_ff) begin
                  state_ff <= ST_MUL;
               end else begin
                  hold_ff  <= hold_decay;
                  state_ff <= ST_OUT;
               end
            end
            ST_MUL: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               hold_ff  <= hold_len;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers; pend_sup/changed for a frame are settled when hold_ff updates
   always_ff @(posedge clock) begin
      if (q_pop) begin
         count_ff        <= q_count;
         ovf_ff          <= q_ovf;
         pend_frame_ff   <= (q_kind == rgcs_pkg::CMD_FRAME);
         pend_sample_ff  <= (hold_on || (q_kind == rgcs_pkg::CMD_FRAME)) ? '0 : q_sample;
         pend_sup_ff     <= hold_on;
         pend_changed_ff <= 1'b0;
         pend_ovf_ff     <= 1'b0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(rate_ff) * PROD_W'(hold_ms_ff);
      end
      if (state_ff == ST_SCALE) begin
         scaled_ff <= SCALED_W'(prod_ff[PROD_W-1:rgcs_pkg::RECIP_PRE_SHIFT])
                      * SCALED_W'(rgcs_pkg::RECIP_125);
      end
      if (state_ff == ST_DECIDE && last_mean_ff < thr_ff) begin
         pend_sup_ff     <= (hold_decay != '0);
         pend_changed_ff <= hold_on != (hold_decay != '0);
         pend_ovf_ff     <= ovf_ff;
      end
      if (state_ff == ST_HOLD) begin
         pend_sup_ff     <= (hold_len != '0);
         pend_changed_ff <= hold_on != (hold_len != '0);
         pend_ovf_ff     <= ovf_ff;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_frame_ff   <= pend_frame_ff;
         rsp_sample_ff  <= pend_sample_ff;
         rsp_mean_ff    <= last_mean_ff;
         rsp_sup_ff     <= pend_sup_ff;
         rsp_changed_ff <= pend_changed_ff;
         rsp_ovf_ff     <= pend_ovf_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.is_frame_result = rsp_frame_ff;
   assign rsp_ch.out_sample      = rsp_sample_ff;
   assign rsp_ch.mean_level      = rsp_mean_ff;
   assign rsp_ch.suppressing     = rsp_sup_ff;
   assign rsp_ch.changed         = rsp_changed_ff;
   assign rsp_ch.frame_overflow  = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_capture_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_frame_ff |-> !rsp_changed_ff && !rsp_ovf_ff)
      else $error("capture transaction carries frame flags");
   a_muted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_frame_ff || rsp_sup_ff) |-> rsp_sample_ff == '0)
      else $error("sample leaks through while suppressed or in a frame result");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_MEAN)
      else $error("divider finished outside the mean wait");
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_MEAN || state_ff == ST_OUT)
      else $error("popped command not dispatched");
`endif

endmodule

>>> hdl/render_gated_capture_suppressor.sv
// Top level of the render-gated capture suppressor (half-duplex echo guard).
// Depends on rgcs_pkg, rgcs_channels, rgcs_front, rgcs_fifo, rgcs_back.
//
//   channel | direction | handshake          | contents
//   req_ch  | in        | valid/ready        | func, sample, frame_end
//   rsp_ch  | out       | valid/ready        | frame summary or processed capture sample
//   csr_*   | in        | csr_we, no stall   | sample_rate, hold_ms, active_threshold
//
// A render sample without frame_end is absorbed by the front and queues nothing.
// A capture sample goes from idle straight to the output state in the back; a frame
// end first waits for the bit-serial mean division and the threshold decision,
// then, when the frame is active, runs product, scale by 1/1000 and hold update.
// The four-entry queue lets the front keep taking transactions while the back
// divides or the response is stalled. Reset is synchronous; no clearing pass.
module render_gated_capture_suppressor #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   rgcs_req_if.sink                        req_ch,
   rgcs_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [rgcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W   = $clog2(MAX_FRAME + 1);
   localparam int SUM_W   = rgcs_pkg::SAMPLE_W + CNT_W;
   localparam int ENTRY_W = 2 + rgcs_pkg::SAMPLE_W + CNT_W + SUM_W;

   logic               q_push;
   logic [ENTRY_W-1:0] q_push_data;
   logic               q_full;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_head;
   logic               q_empty;

   rgcs_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   rgcs_fifo #(
      .DATA_W (ENTRY_W),
      .DEPTH  (rgcs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty)
   );

   rgcs_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> bench/render_gated_capture_suppressor_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for render_gated_capture_suppressor: render frames and capture
// samples go in, every response is predicted by a small tracker class and compared.
// Depends on rgcs_pkg, rgcs_channels and the RTL under hdl/.

typedef struct packed {
   logic                                 is_frame;
   logic signed [rgcs_pkg::SAMPLE_W-1:0] out_sample;
   logic [rgcs_pkg::MEAN_W-1:0]          mean_level;
   logic                                 suppressing;
   logic                                 changed;
   logic                                 frame_overflow;
} guard_result_type;

// Tracks the echo guard's state and the responses still owed by the block.
class guard_tracker_type;
   logic [rgcs_pkg::RATE_W-1:0] sample_rate;
   logic [rgcs_pkg::MS_W-1:0]   hold_ms;
   logic [rgcs_pkg::THR_W-1:0]  threshold;
   logic [27:0]                 level_sum;
   int unsigned                 frame_count;
   bit                          overflow_seen;
   logic [rgcs_pkg::HOLD_W-1:0] hold_remaining;
   logic [rgcs_pkg::MEAN_W-1:0] last_mean;
   guard_result_type            owed[$];
   int                          failures;
   int unsigned                 frame_limit;

   function new(int unsigned limit);
      frame_limit    = limit;
      failures       = 0;
      sample_rate    = rgcs_pkg::SAMPLE_RATE_RST;
      hold_ms        = rgcs_pkg::HOLD_MS_RST;
      threshold      = rgcs_pkg::THRESHOLD_RST;
      level_sum      = '0;
      frame_count    = 0;
      overflow_seen  = 1'b0;
      hold_remaining = '0;
      last_mean      = '0;
   endfunction

   function void set_reg(rgcs_pkg::csr_reg_type r, logic [rgcs_pkg::CSR_DATA_W-1:0] v);
      case (r)
         rgcs_pkg::REG_SAMPLE_RATE:      sample_rate = v[rgcs_pkg::RATE_W-1:0];
         rgcs_pkg::REG_HOLD_MS:          hold_ms     = v[rgcs_pkg::MS_W-1:0];
         rgcs_pkg::REG_ACTIVE_THRESHOLD: threshold   = v[rgcs_pkg::THR_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [rgcs_pkg::HOLD_W-1:0] hold_length();
      longint unsigned rate;
      longint unsigned ms;
      longint unsigned h;
      rate = sample_rate;
      ms   = hold_ms;
      h    = (rate * ms) / rgcs_pkg::MS_PER_S;
      return (h > 64'hFFFF_FFFF) ? '1 : h[rgcs_pkg::HOLD_W-1:0];
   endfunction

   function void absorb_sample(rgcs_pkg::func_type f,
                               logic signed [rgcs_pkg::SAMPLE_W-1:0] s, logic fe);
      guard_result_type r;
      int               mag;
      logic [31:0]      mean;
      logic             was_on;
      r = '0;
      if (f == rgcs_pkg::FUNC_CAPTURE) begin
         r.suppressing = (hold_remaining != 0);
         r.out_sample  = r.suppressing ? '0 : s;
         r.mean_level  = last_mean;
         owed.push_back(r);
         return;
      end
      mag = (s < 0) ? -int'(s) : int'(s);
      if (frame_count < frame_limit) begin
         level_sum += mag;
         frame_count++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (!fe)
         return;
      mean = (frame_count != 0) ? level_sum / frame_count : 0;
      if (mean > 32'hFFFF)
         mean = 32'hFFFF;
      last_mean = mean[rgcs_pkg::MEAN_W-1:0];
      was_on    = (hold_remaining != 0);
      if (last_mean >= threshold)
         hold_remaining = hold_length();
      else if (hold_remaining > frame_count)
         hold_remaining -= frame_count;
      else
         hold_remaining = '0;
      r.is_frame       = 1'b1;
      r.mean_level     = last_mean;
      r.suppressing    = (hold_remaining != 0);
      r.changed        = (was_on != r.suppressing);
      r.frame_overflow = overflow_seen;
      owed.push_back(r);
      level_sum     = '0;
      frame_count   = 0;
      overflow_seen = 1'b0;
   endfunction

   function void note_failure(string what, guard_result_type want, guard_result_type got);
      failures++;
      if (failures <= 10) begin
         $display("%s: expected frame=%0b sample=%0d mean=%0d sup=%0b chg=%0b ovf=%0b",
                  what, want.is_frame, want.out_sample, want.mean_level,
                  want.suppressing, want.changed, want.frame_overflow);
         $display("%s: actual   frame=%0b sample=%0d mean=%0d sup=%0b chg=%0b ovf=%0b",
                  what, got.is_frame, got.out_sample, got.mean_level,
                  got.suppressing, got.changed, got.frame_overflow);
      end
   endfunction

   function void compare_output(guard_result_type got);
      guard_result_type want;
      if (owed.size() == 0) begin
         note_failure("response with nothing owed", '0, got);
         return;
      end
      want = owed.pop_front();
      if (got.is_frame !== want.is_frame || got.out_sample !== want.out_sample ||
          got.mean_level !== want.mean_level || got.suppressing !== want.suppressing ||
          got.changed !== want.changed || got.frame_overflow !== want.frame_overflow)
         note_failure("response mismatch", want, got);
   endfunction
endclass

module render_gated_capture_suppressor_tb;

   localparam int MAX_FRAME      = 4096;
   localparam int LONG_FRAME     = 120;
   localparam int DRAIN_CYCLES   = 200;   // well above the serial division of a frame end
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASE_ITEMS    = 225;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [rgcs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rgcs_pkg::CSR_DATA_W-1:0] csr_wdata;

   rgcs_req_if req_ch();
   rgcs_rsp_if rsp_ch();

   int send_idle_pct;
   int recv_idle_pct;
   int holdoff_req;
   int items_sent;

   guard_tracker_type sb = new(MAX_FRAME);

   render_gated_capture_suppressor #(
      .MAX_FRAME (MAX_FRAME)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one transaction; acceptance is judged mid-cycle, where all signals are settled.
   task automatic send_item(input rgcs_pkg::func_type f,
                            input logic signed [rgcs_pkg::SAMPLE_W-1:0] s,
                            input logic fe);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.sample    <= s;
      req_ch.frame_end <= fe;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (taken !== 1'b1);
      sb.absorb_sample(f, s, fe);
      items_sent++;
   endtask

   task automatic configure(input logic [rgcs_pkg::CSR_DATA_W-1:0] rate, ms, thr);
      csr_we    <= 1'b1;
      csr_index <= rgcs_pkg::REG_SAMPLE_RATE;
      csr_wdata <= rate;
      @(posedge clock);
      sb.set_reg(rgcs_pkg::REG_SAMPLE_RATE, rate);
      csr_index <= rgcs_pkg::REG_HOLD_MS;
      csr_wdata <= ms;
      @(posedge clock);
      sb.set_reg(rgcs_pkg::REG_HOLD_MS, ms);
      csr_index <= rgcs_pkg::REG_ACTIVE_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      sb.set_reg(rgcs_pkg::REG_ACTIVE_THRESHOLD, thr);
      csr_we <= 1'b0;
   endtask

   // Render samples with no frame end produce nothing, so allow the back end time to drain.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_setting();
      logic [rgcs_pkg::CSR_DATA_W-1:0] rate;
      logic [rgcs_pkg::CSR_DATA_W-1:0] ms;
      logic [rgcs_pkg::CSR_DATA_W-1:0] thr;
      case ($urandom_range(4))
         0:       rate = 8000;
         1:       rate = 16000;
         2:       rate = 48000;
         3:       rate = 192000;
         default: rate = $urandom_range(262143);
      endcase
      // short holds mostly, so quiet frames can actually release suppression
      ms  = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(6);
      thr = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(100, 6000);
      configure(rate, ms, thr);
   endtask

   task automatic send_frame(input int len, input int amp);
      logic signed [rgcs_pkg::SAMPLE_W-1:0] s;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) < 3)
            send_item(rgcs_pkg::FUNC_CAPTURE, rgcs_pkg::SAMPLE_W'($urandom), 1'($urandom));
         if ($urandom_range(19) == 0)
            s = rgcs_pkg::SAMPLE_W'($urandom);
         else
            s = rgcs_pkg::SAMPLE_W'($urandom_range(2 * amp) - amp);
         send_item(rgcs_pkg::FUNC_RENDER, s, i == len - 1);
      end
   endtask

   task automatic random_phase(input int quota);
      int target;
      int thr;
      int amp;
      int len;
      target = items_sent + quota;
      while (items_sent < target) begin
         thr = sb.threshold;
         len = ($urandom_range(7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 12);
         case ($urandom_range(7))
            0, 1, 2: amp = 32767;
            3, 4:    amp = thr / 2;
            5, 6:    amp = $urandom_range((thr > 16383) ? 32767 : 2 * thr);
            default: amp = -1;
         endcase
         if (amp < 0) begin
            repeat ($urandom_range(1, 3))
               send_item($urandom_range(1) ? rgcs_pkg::FUNC_CAPTURE : rgcs_pkg::FUNC_RENDER,
                         rgcs_pkg::SAMPLE_W'($urandom), 1'($urandom));
         end else begin
            send_frame(len, amp);
         end
      end
   endtask

   // response side: random ready, plus a long hold-off on request
   initial begin
      int holdoff_seen;
      holdoff_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            rsp_ch.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      guard_result_type got;
      forever begin
         @(negedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1 && reset === 1'b0) begin
            got.is_frame       = rsp_ch.is_frame_result;
            got.out_sample     = rsp_ch.out_sample;
            got.mean_level     = rsp_ch.mean_level;
            got.suppressing    = rsp_ch.suppressing;
            got.changed        = rsp_ch.changed;
            got.frame_overflow = rsp_ch.frame_overflow;
            sb.compare_output(got);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= rgcs_pkg::FUNC_RENDER;
      req_ch.sample    <= '0;
      req_ch.frame_end <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= rgcs_pkg::REG_SAMPLE_RATE;
      csr_wdata        <= '0;
      send_idle_pct = 33;
      recv_idle_pct = 57;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // before any frame: capture passes, mean is zero, frame_end ignored
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh7FFF, 1'b1);
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh8000, 1'b0);
      // full-scale frame switches suppression on
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh7FFF, 1'b0);
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh8000, 1'b1);
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh1234, 1'b0);
      send_item(rgcs_pkg::FUNC_RENDER, 16'shFFFF, 1'b1);
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh0000, 1'b1);
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'shEDCB, 1'b1);
      settle();

      // zero sample rate: an active frame reloads a hold of zero
      configure(0, 16'hFFFF, 0);
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh0000, 1'b1);
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh5A5A, 1'b0);
      settle();

      configure(18'h3FFFF, 16'hFFFF, 0);
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh0001, 1'b1);
      settle();

      // nothing reaches this threshold; a long frame only decays the hold
      configure(18'h3FFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < LONG_FRAME; i++)
         send_item(rgcs_pkg::FUNC_RENDER, rgcs_pkg::SAMPLE_W'($urandom), i == LONG_FRAME - 1);
      send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh0FF0, 1'b0);
      settle();

      // eight-sample hold, released by two quiet four-sample frames, then on again
      configure(8000, 1, 500);
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh4000, 1'b1);
      repeat (2) begin
         repeat (3) send_item(rgcs_pkg::FUNC_RENDER, 16'sh0010, 1'b0);
         send_item(rgcs_pkg::FUNC_RENDER, -16'sh0010, 1'b1);
         send_item(rgcs_pkg::FUNC_CAPTURE, 16'sh2468, 1'b0);
      end
      send_item(rgcs_pkg::FUNC_RENDER, 16'sh7000, 1'b1);
      settle();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int sub = 0; sub < 2; sub++) begin
            random_setting();
            if (mode == 2 && sub == 0) begin
               // responses blocked while captures keep coming: queue fills, input stalls
               holdoff_req++;
               repeat (40)
                  send_item(rgcs_pkg::FUNC_CAPTURE, rgcs_pkg::SAMPLE_W'($urandom), 1'b0);
            end
            random_phase(PHASE_ITEMS);
            settle();
         end
      end

      if (sb.failures == 0 && sb.owed.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
hdl/rgcs_pkg.sv
hdl/rgcs_channels.sv
hdl/rgcs_fifo.sv
hdl/rgcs_front.sv
hdl/rgcs_divider.sv
hdl/rgcs_back.sv
hdl/render_gated_capture_suppressor.sv
bench/render_gated_capture_suppressor_tb.sv
